>>> sv/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RawW    = 19;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_TEMP  = 1'b0,
    OP_PRESS = 1'b1
  } op_e;

  // multiply-unit operand selection per sequencer step
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_T_X1,     // (raw-ac6)*ac5
    ST_T_DEN,
    ST_T_DIV,
    ST_T_B5,
    ST_P_SQ,     // b6*b6
    ST_P_X1A,    // sq*b2
    ST_P_X2A,    // ac2*b6
    ST_P_B3,
    ST_P_X1B,    // ac3*b6
    ST_P_X2B,    // b1*sq
    ST_P_B4,     // ac4*(x3+32768)
    ST_P_B7,     // (raw-b3)*(50000>>oss)
    ST_P_DIV,
    ST_P_SQP,    // (p>>8)^2
    ST_P_M3038,
    ST_P_M7357,
    ST_P_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  localparam logic [31:0] K4000   = 32'd4000;
  localparam logic [31:0] K32768  = 32'd32768;
  localparam logic [31:0] K50000  = 32'd50000;
  localparam logic [31:0] KSign   = 32'h8000_0000;
  localparam logic [31:0] K3038   = 32'd3038;
  localparam logic [31:0] KM7357  = 32'hFFFF_E343;
  localparam logic [31:0] K3791   = 32'd3791;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

endpackage

>>> sv/bpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channel interfaces: input items, results, configuration.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [18:0] raw_value;
  modport source (output valid, op, raw_value, input ready);
  modport sink   (input valid, op, raw_value, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               div_error;
  modport source (output valid, value, div_error, input ready);
  modport sink   (input valid, value, div_error, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/barometric_pressure_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Temperature and pressure compensation with one shared multiplier and a
// serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: write calibration words on the cfg channel (index 0..5) while idle.
// Send items on in_ch: op 0 is a raw temperature (updates stored B5),
// op 1 a raw pressure, already shifted for the oversampling setting.
// Each item yields one transfer on out_ch: value and div_error.
// The time from the accepting edge to the result is set by the bit-serial
// divider, its done strobe and the products on the shared 32x32 multiplier,
// which are formed one at a time. A zero divisor skips the divider and sends
// the error result straight to the output. in_ch is not ready while an item
// is in work; the result is held in an output register, and the next item is
// taken in the cycle after its result transfers at the earliest.
// Reset clears calibration words, oversampling and B5 to zero and leaves
// the core idle. If the receiver stalls, the result holds and in_ch stays
// low on ready until the result is taken.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_core
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_in_if.sink      in_ch,
  bpc_out_if.source   out_ch,
  bpc_cfg_if.sink     cfg_ch
);

  logic [31:0] regs_q [5];
  logic [1:0]  oss_q;
  logic [31:0] b5_q, b5_d;
  state_e      st_q, st_d;
  logic [31:0] raw_q, a_q, b_q, c_q, sq_q, p_q, res_q;
  logic [31:0] a_d, b_d, c_d, sq_d, p_d, res_d;
  logic        op_q, err_q, err_d, neg_q, neg_d;
  logic        ovl_q, ovl_d;
  logic [31:0] ma, mb, prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{regs_q[0][31]}}, regs_q[0][31:16]};
  assign ac2 = {{16{regs_q[0][15]}}, regs_q[0][15:0]};
  assign ac3 = {{16{regs_q[1][31]}}, regs_q[1][31:16]};
  assign ac4 = {16'd0, regs_q[1][15:0]};
  assign ac5 = {16'd0, regs_q[2][31:16]};
  assign ac6 = {16'd0, regs_q[2][15:0]};
  assign b1  = {{16{regs_q[3][31]}}, regs_q[3][31:16]};
  assign b2  = {{16{regs_q[3][15]}}, regs_q[3][15:0]};
  assign mc  = {{16{regs_q[4][31]}}, regs_q[4][31:16]};
  assign md  = {{16{regs_q[4][15]}}, regs_q[4][15:0]};

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st_q == ST_IDLE);
  assign out_ch.valid = (st_q == ST_OUT);
  assign out_ch.value = res_q;
  assign out_ch.div_error = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) regs_q[i] <= '0;
      oss_q <= '0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_e'(cfg_ch.index))
        REG_AC1_AC2: regs_q[0] <= cfg_ch.data;
        REG_AC3_AC4: regs_q[1] <= cfg_ch.data;
        REG_AC5_AC6: regs_q[2] <= cfg_ch.data;
        REG_B1_B2:   regs_q[3] <= cfg_ch.data;
        REG_MC_MD:   regs_q[4] <= cfg_ch.data;
        REG_OSS:     oss_q     <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, low 32 bits of the product
  assign prod = 32'(ma * mb);

  bpc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (in_ch.valid) st_d = (in_ch.op == OP_TEMP) ? ST_T_X1 : ST_P_SQ;
      ST_T_X1:    st_d = ST_T_DEN;
      ST_T_DEN:   st_d = (a_q + md == '0) ? ST_OUT : ST_T_DIV;
      ST_T_DIV:   if (drsp.done) st_d = ST_T_B5;
      ST_T_B5:    st_d = ST_OUT;
      ST_P_SQ:    st_d = ST_P_X1A;
      ST_P_X1A:   st_d = ST_P_X2A;
      ST_P_X2A:   st_d = ST_P_B3;
      ST_P_B3:    st_d = ST_P_X1B;
      ST_P_X1B:   st_d = ST_P_X2B;
      ST_P_X2B:   st_d = ST_P_B4;
      ST_P_B4:    st_d = (prod[31:15] == '0) ? ST_OUT : ST_P_B7;
      ST_P_B7:    st_d = ST_P_DIV;
      ST_P_DIV:   if (drsp.done) st_d = ST_P_SQP;
      ST_P_SQP:   st_d = ST_P_M3038;
      ST_P_M3038: st_d = ST_P_M7357;
      ST_P_M7357: st_d = ST_P_FIN;
      ST_P_FIN:   st_d = ST_OUT;
      ST_OUT:     if (out_ch.ready) st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // datapath and multiplier operand select
  always_comb begin
    logic [31:0] b6, t, q;
    a_d = a_q; b_d = b_q; c_d = c_q; sq_d = sq_q; p_d = p_q;
    res_d = res_q; err_d = err_q; neg_d = neg_q; ovl_d = ovl_q; b5_d = b5_q;
    ma = '0; mb = '0;
    dreq = '0;
    b6 = b5_q - K4000;
    t  = '0;
    q  = neg_q ? (32'd0 - drsp.quot) : drsp.quot;
    unique case (st_q)
      ST_IDLE: ;
      ST_T_X1: begin
        ma = raw_q - ac6; mb = ac5;
        a_d = asr32(prod, 5'd15);
      end
      ST_T_DEN: begin
        t = a_q + md;
        if (t == '0) begin
          res_d = '0; err_d = 1'b1;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = mc[20] ? (32'd0 - (mc << 11)) : (mc << 11);
          dreq.den   = t[31] ? (32'd0 - t) : t;
          neg_d      = mc[20] ^ t[31];
        end
      end
      ST_T_DIV: ;
      ST_T_B5: begin
        t = a_q + q;
        b5_d = t;
        res_d = asr32(t + 32'd8, 5'd4);
        err_d = 1'b0;
      end
      ST_P_SQ: begin
        ma = b6; mb = b6;
        sq_d = asr32(prod, 5'd12);
      end
      ST_P_X1A: begin
        ma = sq_q; mb = b2;
        a_d = asr32(prod, 5'd11);
      end
      ST_P_X2A: begin
        ma = ac2; mb = b6;
        a_d = a_q + asr32(prod, 5'd11);
      end
      ST_P_B3: begin
        t = ((ac1 << 2) + a_q) << oss_q;
        c_d = asr32(t + 32'd2, 5'd2);
      end
      ST_P_X1B: begin
        ma = ac3; mb = b6;
        a_d = asr32(prod, 5'd13);
      end
      ST_P_X2B: begin
        ma = b1; mb = sq_q;
        a_d = asr32(a_q + asr32(prod, 5'd16) + 32'd2, 5'd2);
      end
      ST_P_B4: begin
        ma = ac4; mb = a_q + K32768;
        b_d = prod >> 15;
        if (prod[31:15] == '0) begin
          res_d = '0; err_d = 1'b1;
        end
      end
      ST_P_B7: begin
        ma = raw_q - c_q; mb = K50000 >> oss_q;
        ovl_d = (prod >= KSign);
        dreq.start = 1'b1;
        dreq.num   = (prod >= KSign) ? prod : (prod << 1);
        dreq.den   = b_q;
        neg_d      = 1'b0;
      end
      ST_P_DIV: if (drsp.done) p_d = ovl_q ? (drsp.quot << 1) : drsp.quot;
      ST_P_SQP: begin
        ma = asr32(p_q, 5'd8); mb = asr32(p_q, 5'd8);
        a_d = prod;
      end
      ST_P_M3038: begin
        ma = a_q; mb = K3038;
        a_d = asr32(prod, 5'd16);
      end
      ST_P_M7357: begin
        ma = p_q; mb = KM7357;
        a_d = a_q + asr32(prod, 5'd16);
      end
      ST_P_FIN: begin
        res_d = p_q + asr32(a_q + K3791, 5'd4);
        err_d = 1'b0;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      b5_q <= '0;
    end else begin
      st_q <= st_d;
      b5_q <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_q <= {13'd0, in_ch.raw_value};
      op_q  <= in_ch.op;
    end
    a_q <= a_d; b_q <= b_d; c_q <= c_d; sq_q <= sq_d; p_q <= p_d;
    res_q <= res_d; err_q <= err_d; neg_q <= neg_d; ovl_q <= ovl_d;
  end

  a_b5 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b5_q != $past(b5_q)) |-> ($past(st_q) == ST_T_B5 && op_q == OP_TEMP))
    else $error("b5 changed outside temperature finish");
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_T_DIV || st_q == ST_P_DIV) |-> (drsp.busy || drsp.done))
    else $error("waiting on idle divider");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT && !out_ch.ready) |=> (st_q == ST_OUT && $stable(res_q)))
    else $error("result lost under stall");

endmodule

>>> sv/bpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) den_q <= req_i.den;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  a_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("divider count zero while busy");
  a_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");

endmodule
